[rtl/core/bleudc_pkg.sv]
`timescale 1ns / 1ps
// Package for the unique device counter: hash constants, field widths,
// stream layout and sequencer state codes. No dependencies.
package bleudc_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 32;

  localparam logic [31:0] FNV_BASIS       = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME       = 32'd16777619;
  localparam logic [7:0]  STRONGEST_START = 8'sd127 * -8'sd1;

  localparam logic [31:0] SUM_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] SUM_MIN = 32'h8000_0000;

  localparam int unsigned UNIQUE_W    = 6;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_FIELD_W = 32 + UNIQUE_W + 32 + 8 + 1 + 32;
  localparam int unsigned OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_MUL    = 4'b0010,
    ST_SEARCH = 4'b0100,
    ST_FIN    = 4'b1000
  } state_t;

endpackage

[rtl/core/ble_unique_device_counter.sv]
`timescale 1ns / 1ps
// Unique device counter: FNV-1a hashing of address text, statistics and a
// hash table searched by one shared compare unit. Uses bleudc_pkg.
//
// Usage:
//   Input stream: one transaction per address character. in_tdata holds the
//   character and, on the final character (in_tlast high), the signed
//   strength. in_tuser high makes the transaction a clear: statistics reset,
//   table emptied, partial hash dropped, no result.
//   Output stream: one transaction per completed address, carrying the
//   saturating counters, the strongest strength, the known flag and the hash.
//   Timing: in_tready is high only while the sequencer is idle. A clear is
//   taken in the idle state alone, a non-final character passes through
//   accept and multiply, a final character through accept, multiply, a
//   search of up to TABLE_DEPTH table entries and the final state; the table
//   search reads one entry per cycle through the single registered read port.
//   The result sits in an output register; the block goes on accepting
//   characters while it waits. A further result stalls the sequencer in its
//   final state until out_tready frees the register.
//   Reset: synchronous, active low; statistics return to their start values,
//   table is empty, output register is empty. No clearing pass is needed.
module ble_unique_device_counter #(
  parameter int unsigned TABLE_DEPTH = bleudc_pkg::TABLE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [7:0] address_byte, [15:8] signal_strength
  input  logic [bleudc_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                               in_tlast,
  // [0] mode
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [31:0] advert_count, [37:32] unique_count, [69:38] strength_sum,
  // [77:70] strongest, [78] already_known, [110:79] device_hash, rest zero
  output logic [bleudc_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import bleudc_pkg::*;

  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  state_t           state_r, state_nxt;
  logic [31:0]      hash_acc_r, hash_acc_nxt;
  logic [31:0]      mul_x_r, mul_x_nxt;
  logic             last_r, last_nxt;
  logic [7:0]       rssi_r, rssi_nxt;
  logic [31:0]      h_r, h_nxt;
  logic [31:0]      adv_r, adv_nxt;
  logic [31:0]      sum_r, sum_nxt;
  logic [7:0]       strong_r, strong_nxt;
  logic [CW-1:0]    used_r, used_nxt;
  logic [IW-1:0]    idx_r, idx_nxt;
  logic             known_r, known_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic [31:0]      table_mem [TABLE_DEPTH];
  logic [31:0]      rd_data_r;
  logic [IW-1:0]    rd_addr;
  logic             wr_en;

  logic [31:0]      prod;
  logic [32:0]      sum_ext;
  logic [CW-1:0]    idx_inc;
  logic             in_fire;
  logic             out_free;
  logic             hit;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign prod    = mul_x_r * FNV_PRIME;
  assign sum_ext = {sum_r[31], sum_r} + {{25{rssi_r[7]}}, rssi_r};
  assign idx_inc = CW'(idx_r) + CW'(1);
  assign hit     = (rd_data_r == h_r);
  assign rd_addr = (state_r == ST_SEARCH) ? IW'(idx_inc) : '0;
  assign wr_en   = (state_r == ST_FIN) && out_free && !known_r && (used_r < DEPTH_C);

  always_comb begin
    state_nxt     = state_r;
    hash_acc_nxt  = hash_acc_r;
    mul_x_nxt     = mul_x_r;
    last_nxt      = last_r;
    rssi_nxt      = rssi_r;
    h_nxt         = h_r;
    adv_nxt       = adv_r;
    sum_nxt       = sum_r;
    strong_nxt    = strong_r;
    used_nxt      = used_r;
    idx_nxt       = idx_r;
    known_nxt     = known_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_tuser) begin
            hash_acc_nxt = FNV_BASIS;
            adv_nxt      = '0;
            sum_nxt      = '0;
            strong_nxt   = STRONGEST_START;
            used_nxt     = '0;
          end else begin
            mul_x_nxt = hash_acc_r ^ {24'd0, in_tdata[7:0]};
            last_nxt  = in_tlast;
            rssi_nxt  = in_tdata[15:8];
            state_nxt = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        h_nxt = prod;
        if (!last_r) begin
          hash_acc_nxt = prod;
          state_nxt    = ST_IDLE;
        end else begin
          hash_acc_nxt = FNV_BASIS;
          if (adv_r != '1) adv_nxt = adv_r + 32'd1;
          if (sum_ext[32] != sum_ext[31]) begin
            sum_nxt = sum_ext[32] ? SUM_MIN : SUM_MAX;
          end else begin
            sum_nxt = sum_ext[31:0];
          end
          if ($signed(rssi_r) > $signed(strong_r)) strong_nxt = rssi_r;
          idx_nxt   = '0;
          known_nxt = 1'b0;
          state_nxt = (used_r == '0) ? ST_FIN : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (hit) begin
          known_nxt = 1'b1;
          state_nxt = ST_FIN;
        end else if (idx_inc >= used_r) begin
          state_nxt = ST_FIN;
        end else begin
          idx_nxt = IW'(idx_inc);
        end
      end
      ST_FIN: begin
        if (out_free) begin
          if (wr_en) used_nxt = used_r + CW'(1);
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_TDATA_W'({h_r, known_r, strong_r, sum_r,
                                        UNIQUE_W'(wr_en ? used_r + CW'(1) : used_r),
                                        adv_r});
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      hash_acc_r  <= FNV_BASIS;
      adv_r       <= '0;
      sum_r       <= '0;
      strong_r    <= STRONGEST_START;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hash_acc_r  <= hash_acc_nxt;
      adv_r       <= adv_nxt;
      sum_r       <= sum_nxt;
      strong_r    <= strong_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mul_x_r    <= mul_x_nxt;
    last_r     <= last_nxt;
    rssi_r     <= rssi_nxt;
    h_r        <= h_nxt;
    idx_r      <= idx_nxt;
    known_r    <= known_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) table_mem[used_r[IW-1:0]] <= h_r;
    rd_data_r <= table_mem[rd_addr];
  end

endmodule

[rtl/core/bleudc_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the unique device counter, bound to the top level.
// Uses bleudc_pkg for the stream widths.
module bleudc_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic                               in_tuser,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [bleudc_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import bleudc_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output changed");

  a_busy_after_byte: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser |=> !in_tready)
    else $error("ready right after an address byte");

  a_clear_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |=> in_tready)
    else $error("clear did not finish in one cycle");

endmodule

bind ble_unique_device_counter bleudc_checker u_bleudc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

[tb/bleudc_result_check.sv]
`timescale 1ns / 1ps
// Result checker for the unique device counter: watches both streams, predicts
// each result from the accepted characters and compares it. Uses bleudc_pkg.
module bleudc_result_check (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  input  logic                               in_tready,
  input  logic [bleudc_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                               in_tlast,
  input  logic                               in_tuser,
  input  logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic [bleudc_pkg::OUT_TDATA_W-1:0] out_tdata,
  output int                                 fail_count,
  output int                                 pending,
  output int                                 results_checked,
  output int                                 known_count,
  output int                                 full_count
);
  import bleudc_pkg::*;

  typedef struct {
    logic [31:0] adverts;
    logic [5:0]  devices;
    logic [31:0] sum;
    logic [7:0]  strongest;
    logic        known;
    logic [31:0] hash;
  } tally_t;

  localparam longint SUM_HI = 2147483647;
  localparam longint SUM_LO = -SUM_HI - 1;

  tally_t             tally_q[$];
  logic [31:0]        hash_acc;
  logic [31:0]        adverts_seen;
  logic signed [31:0] sum_acc;
  logic signed [7:0]  peak;
  int unsigned        stored;
  logic [31:0]        device_table[TABLE_DEPTH_DEF];

  initial begin
    fail_count      = 0;
    pending         = 0;
    results_checked = 0;
    known_count     = 0;
    full_count      = 0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns mismatch %s: got %h, expected %h", $time, what, got, want);
    fail_count++;
  endtask

  task automatic restart_tally();
    hash_acc     = FNV_BASIS;
    adverts_seen = '0;
    sum_acc      = '0;
    peak         = STRONGEST_START;
    stored       = 0;
  endtask

  task automatic fold_character(input logic mode, input logic [7:0] ch, input logic last,
                                input logic signed [7:0] rssi);
    logic [31:0] h;
    longint      total;
    logic        known;
    tally_t      t;
    if (mode) begin
      restart_tally();
      return;
    end
    h = (hash_acc ^ {24'd0, ch}) * FNV_PRIME;
    if (!last) begin
      hash_acc = h;
      return;
    end
    hash_acc = FNV_BASIS;
    if (adverts_seen != '1) adverts_seen++;
    total = longint'(sum_acc) + longint'(rssi);
    if (total > SUM_HI) total = SUM_HI;
    if (total < SUM_LO) total = SUM_LO;
    sum_acc = total[31:0];
    if (rssi > peak) peak = rssi;
    known = 1'b0;
    for (int i = 0; i < stored; i++)
      if (device_table[i] == h) known = 1'b1;
    if (!known && stored < TABLE_DEPTH_DEF) begin
      device_table[stored] = h;
      stored++;
    end else if (!known) begin
      full_count++;
    end
    if (known) known_count++;
    t.adverts   = adverts_seen;
    t.devices   = stored[5:0];
    t.sum       = sum_acc;
    t.strongest = peak;
    t.known     = known;
    t.hash      = h;
    tally_q.push_back(t);
  endtask

  task automatic compare_result();
    tally_t got;
    tally_t want;
    got.adverts   = out_tdata[31:0];
    got.devices   = out_tdata[37:32];
    got.sum       = out_tdata[69:38];
    got.strongest = out_tdata[77:70];
    got.known     = out_tdata[78];
    got.hash      = out_tdata[110:79];
    if (out_tdata[OUT_TDATA_W-1:OUT_FIELD_W] != '0)
      report_mismatch("padding", 32'(out_tdata[OUT_TDATA_W-1:OUT_FIELD_W]), '0);
    if (tally_q.size() == 0) begin
      report_mismatch("unexpected result, hash", got.hash, '0);
      return;
    end
    want = tally_q.pop_front();
    results_checked++;
    if (got.adverts !== want.adverts)
      report_mismatch("advert_count", got.adverts, want.adverts);
    if (got.devices !== want.devices)
      report_mismatch("unique_count", 32'(got.devices), 32'(want.devices));
    if (got.sum !== want.sum)
      report_mismatch("strength_sum", got.sum, want.sum);
    if (got.strongest !== want.strongest)
      report_mismatch("strongest", 32'(got.strongest), 32'(want.strongest));
    if (got.known !== want.known)
      report_mismatch("already_known", 32'(got.known), 32'(want.known));
    if (got.hash !== want.hash)
      report_mismatch("device_hash", got.hash, want.hash);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      restart_tally();
      tally_q.delete();
    end else begin
      if (out_tvalid && out_tready) compare_result();
      if (in_tvalid && in_tready)
        fold_character(in_tuser, in_tdata[7:0], in_tlast, in_tdata[15:8]);
    end
    pending = tally_q.size();
  end

endmodule

[tb/tb_ble_unique_device_counter.sv]
`timescale 1ns / 1ps
// Testbench top for the unique device counter: clock, reset, address stimulus
// and stream back-pressure. Needs bleudc_pkg, the block and bleudc_result_check.
module tb_ble_unique_device_counter;
  import bleudc_pkg::*;

  localparam int ITEMS_TARGET = 1700;
  localparam int STALL_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 300;
  localparam int POOL         = 48;
  localparam int MAX_TEXT     = 17;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tlast   = 1'b0;
  logic                   in_tuser   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  int fail_count;
  int pending;
  int results_checked;
  int known_count;
  int full_count;

  bit idle_on;
  bit rx_hold_request;
  int items_sent;
  int clears_sent;

  logic [7:0] addr_text[POOL][MAX_TEXT];
  int         addr_len[POOL];

  always #6 clk = ~clk;

  ble_unique_device_counter DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  bleudc_result_check u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tlast       (in_tlast),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .fail_count     (fail_count),
    .pending        (pending),
    .results_checked(results_checked),
    .known_count    (known_count),
    .full_count     (full_count)
  );

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (rx_hold_request) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        rx_hold_request = 1'b0;
      end else begin
        out_tready <= !(idle_on && $urandom_range(99) < 38);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("tb_ble_unique_device_counter NOT OK");
    $finish;
  end

  function automatic logic [7:0] pick_strength();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 8'h80;
    if (r == 1) return 8'h7F;
    return 8'($urandom_range(255));
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(input logic mode, input logic [7:0] ch, input logic last,
                           input logic [7:0] strength);
    while (idle_on && $urandom_range(99) < 38) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 16'($urandom_range(65535));
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {strength, ch};
    in_tlast  <= last;
    in_tuser  <= mode;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    items_sent++;
    if (mode) clears_sent++;
  endtask

  task automatic send_clear();
    send_item(1'b1, 8'($urandom_range(255)), 1'($urandom_range(1)),
              8'($urandom_range(255)));
  endtask

  // idx < 0 sends a fresh random address
  task automatic send_advert(input int idx);
    int n;
    n = (idx < 0) ? $urandom_range(1, 6) : addr_len[idx];
    for (int i = 0; i < n; i++)
      send_item(1'b0, (idx < 0) ? 8'($urandom_range(255)) : addr_text[idx][i],
                i == n - 1, pick_strength());
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic run_random(input int stop_at, input bit with_clears);
    int r;
    while (items_sent < stop_at) begin
      r = $urandom_range(99);
      if (with_clears && r < 4) begin
        send_clear();
      end else if (with_clears && r < 7) begin
        // abandoned address: some characters, then a clear
        repeat ($urandom_range(1, 3))
          send_item(1'b0, 8'($urandom_range(255)), 1'b0, pick_strength());
        send_clear();
      end else if (r < 12) begin
        send_advert(-1);
      end else begin
        send_advert($urandom_range(POOL - 1));
      end
    end
  endtask

  initial begin
    int d;
    items_sent      = 0;
    clears_sent     = 0;
    idle_on         = 1'b1;
    rx_hold_request = 1'b0;

    for (int p = 0; p < POOL; p++) begin
      addr_len[p] = (p % 8 == 0) ? MAX_TEXT : $urandom_range(2, 6);
      for (int i = 0; i < MAX_TEXT; i++) begin
        d = $urandom_range(15);
        if (p % 8 != 0) addr_text[p][i] = 8'($urandom_range(255));
        else if (i % 3 == 2) addr_text[p][i] = 8'h3A;
        else addr_text[p][i] = (d < 10) ? 8'(8'h30 + d) : 8'(8'h37 + d);
      end
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: strength extremes, repeat device, clear mid-address
    send_item(1'b0, 8'h41, 1'b1, 8'h7F);
    send_item(1'b0, 8'h00, 1'b0, 8'h00);
    send_item(1'b0, 8'hFF, 1'b1, 8'h80);
    send_item(1'b0, 8'h41, 1'b1, 8'h81);
    send_item(1'b0, 8'h30, 1'b0, 8'hFF);
    send_clear();
    send_item(1'b0, 8'h30, 1'b1, 8'h00);
    send_item(1'b0, 8'h7F, 1'b0, 8'h55);
    send_item(1'b0, 8'h80, 1'b0, 8'hAA);
    send_item(1'b0, 8'h55, 1'b0, 8'h7F);
    send_item(1'b0, 8'hAA, 1'b1, 8'h01);
    send_item(1'b1, 8'hFF, 1'b1, 8'hFF);
    send_item(1'b1, 8'h00, 1'b0, 8'h00);
    send_item(1'b0, 8'h41, 1'b1, 8'hFF);
    send_item(1'b0, 8'h41, 1'b1, 8'h80);
    wait_drained();

    run_random(items_sent + 600, 1'b1);

    // long receiver hold-off while the sender keeps offering
    rx_hold_request = 1'b1;
    repeat (8) send_advert($urandom_range(8, POOL - 1));
    wait_drained();

    // no idling; fill the table past its depth, then hit it while full
    idle_on = 1'b0;
    send_clear();
    for (int p = 0; p < 40; p++) send_advert(p);
    run_random(items_sent + 300, 1'b0);
    wait_drained();

    idle_on = 1'b1;
    run_random(ITEMS_TARGET, 1'b1);
    wait_drained();
    repeat (TABLE_DEPTH_DEF + 8) @(negedge clk);

    $display("Covered %0d input transactions (%0d clears), %0d results compared,",
             items_sent, clears_sent, results_checked);
    $display("  %0d repeat devices and %0d new devices seen with the table full.",
             known_count, full_count);
    if (fail_count == 0) begin
      $display("tb_ble_unique_device_counter OK");
    end else begin
      $display("tb_ble_unique_device_counter NOT OK");
    end
    $finish;
  end

endmodule
